### rtl/usbp_pkg.sv
// Package for the USB host port state machine: item types, codes and helpers.
package usbp_pkg;

  // Width of the phase timer; arrival times are resized to it.
  localparam int unsigned TIME_WIDTH = 32;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Event codes
  localparam logic [KIND_W-1:0] EV_POLL       = 3'd0;
  localparam logic [KIND_W-1:0] EV_CONNECT    = 3'd1;
  localparam logic [KIND_W-1:0] EV_DISCONNECT = 3'd2;
  localparam logic [KIND_W-1:0] EV_PORT_UP    = 3'd3;
  localparam logic [KIND_W-1:0] EV_PORT_DOWN  = 3'd4;

  // Reported state codes
  localparam logic [STATE_W-1:0] PS_IDLE        = 3'd0;
  localparam logic [STATE_W-1:0] PS_DEBOUNCE    = 3'd1;
  localparam logic [STATE_W-1:0] PS_RESET       = 3'd2;
  localparam logic [STATE_W-1:0] PS_WAIT_ATTACH = 3'd3;
  localparam logic [STATE_W-1:0] PS_UP_WAIT     = 3'd4;
  localparam logic [STATE_W-1:0] PS_UP          = 3'd5;
  localparam logic [STATE_W-1:0] PS_DOWN        = 3'd6;
  localparam logic [STATE_W-1:0] PS_SETTLE      = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_HOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_WAIT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd3;

  // Configuration defaults
  localparam logic [CFG_W-1:0] DEBOUNCE_DEF   = 16'd200;
  localparam logic [CFG_W-1:0] RESET_HOLD_DEF = 16'd60;
  localparam logic [CFG_W-1:0] UP_WAIT_DEF    = 16'd10;
  localparam logic [CFG_W-1:0] SETTLE_DEF     = 16'd500;

  // One-hot port state
  typedef enum logic [7:0] {
    ST_IDLE        = 8'b0000_0001,
    ST_DEBOUNCE    = 8'b0000_0010,
    ST_RESET       = 8'b0000_0100,
    ST_WAIT_ATTACH = 8'b0000_1000,
    ST_UP_WAIT     = 8'b0001_0000,
    ST_UP          = 8'b0010_0000,
    ST_DOWN        = 8'b0100_0000,
    ST_SETTLE      = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [31:0]       now_ms;
    logic              port_stale;
  } in_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] port_state;
    logic               assert_reset;
    logic               release_reset;
    logic               port_came_up;
    logic               port_went_down;
    logic               run_host_process;
    logic               illegal_event;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] reset_hold_ms;
    logic [CFG_W-1:0] up_wait_ms;
    logic [CFG_W-1:0] disconnect_settle_ms;
  } cfg_t;

  // Map the one-hot state onto the reported code
  function automatic logic [STATE_W-1:0] state_code(state_t s);
    logic [STATE_W-1:0] c;
    case (s)
      ST_IDLE:        c = PS_IDLE;
      ST_DEBOUNCE:    c = PS_DEBOUNCE;
      ST_RESET:       c = PS_RESET;
      ST_WAIT_ATTACH: c = PS_WAIT_ATTACH;
      ST_UP_WAIT:     c = PS_UP_WAIT;
      ST_UP:          c = PS_UP;
      ST_DOWN:        c = PS_DOWN;
      ST_SETTLE:      c = PS_SETTLE;
      default:        c = PS_IDLE;
    endcase
    return c;
  endfunction

endpackage

### rtl/usb_host_port_state_machine_core.sv
// Top level of the USB host port state machine: input register, state, result register.
//
// Each accepted event item yields exactly one result item holding the new port
// state and one-item action pulses. The block takes one item per clock cycle
// while out_ready is high: an item is held in the input register, is resolved
// by the transition logic (one 32-bit subtract and compare against the delay
// of the current phase) and lands in the result register. While a result
// waits on out_ready, the input register takes one more item and then in_ready
// drops until the result leaves. Configuration writes are taken in any cycle
// (cfg_ready is always high) and should only be issued while no item is in
// flight; reset restores the default delays of 200, 60, 10 and 500 ms.
module usb_host_port_state_machine_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  usbp_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output usbp_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [usbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [usbp_pkg::CFG_W-1:0]          cfg_data
);
  import usbp_pkg::*;

  cfg_t                  cfg_r;
  state_t                state_r, state_nxt;
  logic [TIME_WIDTH-1:0] phase_start_r;
  logic [TIME_WIDTH-1:0] now_t;
  logic                  phase_load;
  logic                  s1_valid_r;
  in_item_t              s1_item_r;
  logic                  out_valid_r;
  out_item_t             out_item_r;
  out_item_t             result;
  logic                  out_free, s1_adv;

  // Handshake: stage advances when the result register is free or draining
  assign out_free  = !out_valid_r || out_ready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms          <= DEBOUNCE_DEF;
      cfg_r.reset_hold_ms        <= RESET_HOLD_DEF;
      cfg_r.up_wait_ms           <= UP_WAIT_DEF;
      cfg_r.disconnect_settle_ms <= SETTLE_DEF;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE:   cfg_r.debounce_ms          <= cfg_data;
        CFG_RESET_HOLD: cfg_r.reset_hold_ms        <= cfg_data;
        CFG_UP_WAIT:    cfg_r.up_wait_ms           <= cfg_data;
        CFG_SETTLE:     cfg_r.disconnect_settle_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_item_r <= in_item;
  end

  // Transition logic
  usbp_fsm u_fsm (
    .state       (state_r),
    .phase_start (phase_start_r),
    .cfg         (cfg_r),
    .item        (s1_item_r),
    .state_nxt   (state_nxt),
    .phase_load  (phase_load),
    .now_t       (now_t),
    .result      (result)
  );

  // Port state and phase timer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_start_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
      if (phase_load) phase_start_r <= now_t;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_item_r <= result;
  end

endmodule

### rtl/usbp_fsm.sv
// Transition logic of the port state machine: next state, timer load, result item.
module usbp_fsm (
  input  usbp_pkg::state_t                     state,
  input  logic [usbp_pkg::TIME_WIDTH-1:0]      phase_start,
  input  usbp_pkg::cfg_t                       cfg,
  input  usbp_pkg::in_item_t                   item,
  output usbp_pkg::state_t                     state_nxt,
  output logic                                 phase_load,
  output logic [usbp_pkg::TIME_WIDTH-1:0]      now_t,
  output usbp_pkg::out_item_t                  result
);
  import usbp_pkg::*;

  logic [TIME_WIDTH-1:0] elapsed;
  logic [CFG_W-1:0]      delay;
  logic                  over;
  logic                  is_poll, is_conn, is_disc, is_up, is_down;
  logic                  a_rst, r_rst, came_up, went_down, run, bad;

  assign now_t = TIME_WIDTH'(item.now_ms);

  // Single elapsed-time compare, delay picked by state
  always_comb begin
    case (state)
      ST_DEBOUNCE: delay = cfg.debounce_ms;
      ST_RESET:    delay = cfg.reset_hold_ms;
      ST_UP_WAIT:  delay = cfg.up_wait_ms;
      default:     delay = cfg.disconnect_settle_ms;
    endcase
  end

  assign elapsed = now_t - phase_start;
  assign over    = elapsed > TIME_WIDTH'(delay);

  assign is_poll = item.kind == EV_POLL;
  assign is_conn = item.kind == EV_CONNECT;
  assign is_disc = item.kind == EV_DISCONNECT;
  assign is_up   = item.kind == EV_PORT_UP;
  assign is_down = item.kind == EV_PORT_DOWN;

  // State transitions
  always_comb begin
    state_nxt  = state;
    phase_load = 1'b0;
    a_rst      = 1'b0;
    r_rst      = 1'b0;
    came_up    = 1'b0;
    went_down  = 1'b0;
    run        = 1'b0;
    bad        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (is_conn) begin
          state_nxt  = ST_DEBOUNCE;
          phase_load = 1'b1;
        end else if (!is_poll) begin
          bad = 1'b1;
        end
      end
      ST_DEBOUNCE: begin
        if (is_poll) begin
          if (over) begin
            state_nxt  = ST_RESET;
            phase_load = 1'b1;
            a_rst      = 1'b1;
          end
        end else if (is_disc) begin
          state_nxt = ST_IDLE;
        end else begin
          bad = 1'b1;
        end
      end
      ST_RESET: begin
        if (is_poll) begin
          if (over) begin
            state_nxt  = ST_WAIT_ATTACH;
            phase_load = 1'b1;
            r_rst      = 1'b1;
          end
        end else if (is_disc) begin
          state_nxt = ST_IDLE;
        end else begin
          bad = 1'b1;
        end
      end
      ST_WAIT_ATTACH: begin
        if (is_up) begin
          state_nxt  = ST_UP_WAIT;
          phase_load = 1'b1;
        end else if (is_disc) begin
          state_nxt = ST_IDLE;
        end else if (!is_poll) begin
          bad = 1'b1;
        end
      end
      ST_UP_WAIT: begin
        if (is_poll) begin
          if (over) begin
            state_nxt = ST_UP;
            came_up   = 1'b1;
          end
        end else if (is_down) begin
          // pipes never opened, so no teardown
          state_nxt = ST_DOWN;
        end else begin
          bad = 1'b1;
        end
      end
      ST_UP: begin
        if (is_poll) begin
          run = 1'b1;
        end else if (is_down) begin
          state_nxt = ST_DOWN;
          went_down = 1'b1;
        end else if (!is_conn) begin
          bad = 1'b1;
        end
      end
      ST_DOWN: begin
        if (is_poll) begin
          // stale port: go back through bus reset
          if (item.port_stale) begin
            state_nxt  = ST_RESET;
            phase_load = 1'b1;
            a_rst      = 1'b1;
          end
        end else if (is_disc) begin
          state_nxt  = ST_SETTLE;
          phase_load = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      ST_SETTLE: begin
        if (is_poll) begin
          if (over) state_nxt = ST_IDLE;
        end else if (is_conn) begin
          // reconnect restarts debounce
          state_nxt  = ST_DEBOUNCE;
          phase_load = 1'b1;
        end else if (!is_disc) begin
          bad = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign result.port_state       = state_code(state_nxt);
  assign result.assert_reset     = a_rst;
  assign result.release_reset    = r_rst;
  assign result.port_came_up     = came_up;
  assign result.port_went_down   = went_down;
  assign result.run_host_process = run;
  assign result.illegal_event    = bad;

endmodule

### sim/tb.sv
// Testbench for usb_host_port_state_machine_core: predicted port states and action pulses.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import usbp_pkg::*;

  // Event codes with no name in the package; all are illegal in every state
  localparam logic [KIND_W-1:0] EV_OTHER   = 3'd5;
  localparam logic [KIND_W-1:0] EV_UNDEF_A = 3'd6;
  localparam logic [KIND_W-1:0] EV_UNDEF_B = 3'd7;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned MAX_PRINTS  = 100;

  // Expected-result tracker: holds its own copy of the port state machine
  class port_scoreboard;
    logic [CFG_W-1:0]      debounce_ms, reset_hold_ms, up_wait_ms, settle_ms;
    logic [STATE_W-1:0]    port_state;
    logic [TIME_WIDTH-1:0] phase_start;
    out_item_t             expected_q[$];
    int unsigned           errors;
    int unsigned           n_results;

    function new();
      debounce_ms   = DEBOUNCE_DEF;
      reset_hold_ms = RESET_HOLD_DEF;
      up_wait_ms    = UP_WAIT_DEF;
      settle_ms     = SETTLE_DEF;
      port_state    = PS_IDLE;
      phase_start   = '0;
      errors        = 0;
      n_results     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_DEBOUNCE:   debounce_ms   = val;
        CFG_RESET_HOLD: reset_hold_ms = val;
        CFG_UP_WAIT:    up_wait_ms    = val;
        default:        settle_ms     = val;
      endcase
    endfunction

    // Delay that ends the current phase; zero where the phase has no timer
    function logic [TIME_WIDTH-1:0] phase_delay();
      case (port_state)
        PS_DEBOUNCE: return TIME_WIDTH'(debounce_ms);
        PS_RESET:    return TIME_WIDTH'(reset_hold_ms);
        PS_UP_WAIT:  return TIME_WIDTH'(up_wait_ms);
        PS_SETTLE:   return TIME_WIDTH'(settle_ms);
        default:     return '0;
      endcase
    endfunction

    task report(string msg);
      errors++;
      // keep the log short when the block is badly broken
      if (errors <= MAX_PRINTS) $display("mismatch: %s", msg);
    endtask

    // Step the state machine for one accepted event item
    function void note_event(in_item_t it);
      out_item_t             want;
      logic                  over;
      logic [TIME_WIDTH-1:0] now;
      now  = it.now_ms;
      over = (now - phase_start) > phase_delay();
      want = '0;
      case (port_state)
        PS_IDLE:
          if (it.kind == EV_CONNECT) begin
            port_state  = PS_DEBOUNCE;
            phase_start = now;
          end else if (it.kind != EV_POLL) want.illegal_event = 1'b1;
        PS_DEBOUNCE:
          if (it.kind == EV_POLL) begin
            if (over) begin
              port_state = PS_RESET;
              phase_start = now;
              want.assert_reset = 1'b1;
            end
          end else if (it.kind == EV_DISCONNECT) port_state = PS_IDLE;
          else want.illegal_event = 1'b1;
        PS_RESET:
          if (it.kind == EV_POLL) begin
            if (over) begin
              port_state = PS_WAIT_ATTACH;
              phase_start = now;
              want.release_reset = 1'b1;
            end
          end else if (it.kind == EV_DISCONNECT) port_state = PS_IDLE;
          else want.illegal_event = 1'b1;
        PS_WAIT_ATTACH:
          // no timeout here: a poll does nothing
          if (it.kind == EV_PORT_UP) begin
            port_state  = PS_UP_WAIT;
            phase_start = now;
          end else if (it.kind == EV_DISCONNECT) port_state = PS_IDLE;
          else if (it.kind != EV_POLL) want.illegal_event = 1'b1;
        PS_UP_WAIT:
          if (it.kind == EV_POLL) begin
            if (over) begin
              port_state = PS_UP;
              want.port_came_up = 1'b1;
            end
          end else if (it.kind == EV_PORT_DOWN) port_state = PS_DOWN; // pipes never opened
          else want.illegal_event = 1'b1;
        PS_UP:
          if (it.kind == EV_POLL) want.run_host_process = 1'b1;
          else if (it.kind == EV_PORT_DOWN) begin
            port_state = PS_DOWN;
            want.port_went_down = 1'b1;
          end else if (it.kind != EV_CONNECT) want.illegal_event = 1'b1;
        PS_DOWN:
          if (it.kind == EV_POLL) begin
            if (it.port_stale) begin
              port_state = PS_RESET;
              phase_start = now;
              want.assert_reset = 1'b1;
            end
          end else if (it.kind == EV_DISCONNECT) begin
            port_state  = PS_SETTLE;
            phase_start = now;
          end else want.illegal_event = 1'b1;
        default:
          // settle: reconnect restarts debounce, repeated disconnect is dropped
          if (it.kind == EV_POLL) begin
            if (over) port_state = PS_IDLE;
          end else if (it.kind == EV_CONNECT) begin
            port_state  = PS_DEBOUNCE;
            phase_start = now;
          end else if (it.kind != EV_DISCONNECT) want.illegal_event = 1'b1;
      endcase
      want.port_state = port_state;
      expected_q.push_back(want);
    endfunction

    // Compare one result item against the oldest expectation
    task check_result(out_item_t got);
      out_item_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", n_results));
        return;
      end
      want = expected_q.pop_front();
      if (got.port_state !== want.port_state)
        report($sformatf("result %0d port_state %0d, want %0d",
                         n_results, got.port_state, want.port_state));
      if (got.assert_reset !== want.assert_reset)
        report($sformatf("result %0d assert_reset %b, want %b",
                         n_results, got.assert_reset, want.assert_reset));
      if (got.release_reset !== want.release_reset)
        report($sformatf("result %0d release_reset %b, want %b",
                         n_results, got.release_reset, want.release_reset));
      if (got.port_came_up !== want.port_came_up)
        report($sformatf("result %0d port_came_up %b, want %b",
                         n_results, got.port_came_up, want.port_came_up));
      if (got.port_went_down !== want.port_went_down)
        report($sformatf("result %0d port_went_down %b, want %b",
                         n_results, got.port_went_down, want.port_went_down));
      if (got.run_host_process !== want.run_host_process)
        report($sformatf("result %0d run_host_process %b, want %b",
                         n_results, got.run_host_process, want.run_host_process));
      if (got.illegal_event !== want.illegal_event)
        report($sformatf("result %0d illegal_event %b, want %b",
                         n_results, got.illegal_event, want.illegal_event));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  port_scoreboard        sb;
  logic [TIME_WIDTH-1:0] wall_ms;
  logic                  jitter_on = 1'b0;
  int unsigned           ready_hold = 0;
  int unsigned           quiet_cycles = 0;

  usb_host_port_state_machine_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: stalls at random while jitter is on
  always @(negedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (jitter_on && $urandom_range(0, 7) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", STALL_LIMIT);
      $display("FAIL usb_host_port_state_machine_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t make_event(logic [KIND_W-1:0] kind, logic [31:0] now,
                                          logic stale);
    in_item_t it;
    it.kind       = kind;
    it.now_ms     = now;
    it.port_stale = stale;
    return it;
  endfunction

  // Offer one event item, with an optional idle burst first
  task automatic send_event(in_item_t it);
    int unsigned gap;
    gap = 0;
    if (jitter_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_event(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_delays(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] hold,
                            logic [CFG_W-1:0] upw, logic [CFG_W-1:0] settle);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_RESET_HOLD, hold);
    write_reg(CFG_UP_WAIT, upw);
    write_reg(CFG_SETTLE, settle);
  endtask

  // Stop sending and wait until every expected result is in
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly the event a live port would see next, with some noise mixed in
  function automatic in_item_t next_random_event();
    logic [KIND_W-1:0]     kind;
    logic [TIME_WIDTH-1:0] now, span;
    logic                  stale;
    int unsigned           pick;
    pick  = $urandom_range(0, 99);
    stale = 1'($urandom_range(0, 1));
    if (pick < 12) begin
      now     = $urandom;
      wall_ms = now;
      return make_event(KIND_W'($urandom_range(0, 7)), now, stale);
    end
    case (sb.port_state)
      PS_IDLE:        kind = (pick < 75) ? EV_CONNECT : EV_POLL;
      PS_DEBOUNCE,
      PS_RESET:       kind = (pick < 88) ? EV_POLL : EV_DISCONNECT;
      PS_WAIT_ATTACH: kind = (pick < 70) ? EV_PORT_UP : (pick < 88) ? EV_POLL : EV_DISCONNECT;
      PS_UP_WAIT:     kind = (pick < 85) ? EV_POLL : EV_PORT_DOWN;
      PS_UP:          kind = (pick < 55) ? EV_POLL : (pick < 70) ? EV_CONNECT :
                             (pick < 76) ? EV_OTHER : EV_PORT_DOWN;
      PS_DOWN:        kind = (pick < 60) ? EV_POLL : EV_DISCONNECT;
      default:        kind = (pick < 70) ? EV_POLL : (pick < 85) ? EV_CONNECT : EV_DISCONNECT;
    endcase
    // polls in timed phases land on, just past, or short of the delay
    if (kind == EV_POLL &&
        sb.port_state inside {PS_DEBOUNCE, PS_RESET, PS_UP_WAIT, PS_SETTLE}) begin
      span = sb.phase_delay();
      case ($urandom_range(0, 3))
        0:       span = span;
        1:       span = span + 1;
        2:       span = $urandom_range(0, span);
        default: span = span + 1 + $urandom_range(0, 40);
      endcase
      now = sb.phase_start + span;
    end else begin
      now = wall_ms + $urandom_range(0, 30);
    end
    wall_ms = now;
    return make_event(kind, now, stale);
  endfunction

  task automatic run_random(int unsigned n, logic calm);
    for (int unsigned i = 0; i < n; i++) begin
      if (calm) jitter_on = 1'b0;
      else if (i % 40 == 0) jitter_on = ($urandom_range(0, 3) != 0);
      send_event(next_random_event());
    end
  endtask

  // Walk every state and special case under the default delays, across the time wrap
  task automatic run_directed();
    logic [31:0] t, r, u, q, s;
    t = 32'hFFFF_FF80;
    send_event(make_event(EV_POLL, t, 1'b0));
    send_event(make_event(EV_DISCONNECT, 32'h0000_0000, 1'b0));
    send_event(make_event(EV_UNDEF_A, 32'h0000_0001, 1'b0));
    send_event(make_event(EV_UNDEF_B, 32'hFFFF_FFFF, 1'b1));
    send_event(make_event(EV_CONNECT, t, 1'b0));
    send_event(make_event(EV_POLL, t + 200, 1'b0));      // equal to the delay: stays
    r = t + 201;
    send_event(make_event(EV_POLL, r, 1'b0));            // bus reset begins
    send_event(make_event(EV_CONNECT, r, 1'b0));
    send_event(make_event(EV_POLL, r + 61, 1'b0));       // bus reset ends
    send_event(make_event(EV_PORT_DOWN, r + 62, 1'b0));
    send_event(make_event(EV_POLL, r + 65, 1'b1));       // attach wait has no timeout
    u = r + 70;
    send_event(make_event(EV_PORT_UP, u, 1'b0));
    send_event(make_event(EV_PORT_DOWN, u + 1, 1'b0));   // down before up: no teardown
    send_event(make_event(EV_POLL, u + 3, 1'b0));
    q = u + 5;
    send_event(make_event(EV_POLL, q, 1'b1));            // stale port re-enters reset
    q = q + 61;
    send_event(make_event(EV_POLL, q, 1'b0));
    send_event(make_event(EV_PORT_UP, q, 1'b0));
    send_event(make_event(EV_POLL, q + 10, 1'b0));
    send_event(make_event(EV_POLL, q + 11, 1'b0));       // port comes up
    send_event(make_event(EV_POLL, q + 12, 1'b1));
    send_event(make_event(EV_CONNECT, q + 13, 1'b0));    // ignored while up
    send_event(make_event(EV_PORT_DOWN, q + 14, 1'b0));
    s = q + 20;
    send_event(make_event(EV_DISCONNECT, s, 1'b0));
    send_event(make_event(EV_DISCONNECT, s + 1, 1'b0));  // ignored while settling
    send_event(make_event(EV_CONNECT, s + 5, 1'b0));     // reconnect restarts debounce
    send_event(make_event(EV_DISCONNECT, s + 6, 1'b1));
  endtask

  // Main sequence
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    sb        = new();
    wall_ms   = $urandom;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default delays
    jitter_on = 1'b1;
    run_directed();
    run_random(150, 1'b0);
    drain();

    // shortest delays
    set_delays('0, '0, '0, '0);
    run_random(150, 1'b0);
    drain();

    // longest delays, timer crossing the wrap
    set_delays('1, '1, '1, '1);
    wall_ms = 32'hFFFF_0000;
    run_random(150, 1'b0);
    drain();

    // short random delays
    set_delays(CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 300)),
               CFG_W'($urandom_range(0, 300)), CFG_W'($urandom_range(0, 300)));
    run_random(200, 1'b0);
    drain();

    // full-range random delays, then a stretch at full rate
    set_delays(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    run_random(150, 1'b0);
    run_random(150, 1'b1);

    drain();
    repeat (8) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("PASS usb_host_port_state_machine_core");
    end else begin
      $display("FAIL usb_host_port_state_machine_core");
    end
    $finish;
  end

endmodule

### files.f
rtl/usbp_pkg.sv
rtl/usbp_fsm.sv
rtl/usb_host_port_state_machine_core.sv
sim/tb.sv
